// ----- rtl/itsi_pkg.sv -----
// Package for the IMU time sync interpolator: item structs, constants and codes.
// Used by itsi_divsqrt and the top level; depends on nothing.
`default_nettype none
package itsi_pkg;

    localparam int unsigned FIFO_DEPTH_DEF = 16;
    localparam logic [31:0] MAX_GAP_RST = 32'd200000;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_SYNC = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] timestamp;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] gyro_x;
        logic signed [31:0] gyro_y;
        logic signed [31:0] gyro_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } in_item_t;

    typedef struct packed {
        logic        sync_status;
        logic [31:0] out_time;
        logic signed [31:0] out_accel_x;
        logic signed [31:0] out_accel_y;
        logic signed [31:0] out_accel_z;
        logic signed [31:0] out_gyro_x;
        logic signed [31:0] out_gyro_y;
        logic signed [31:0] out_gyro_z;
        logic signed [15:0] out_quat_x;
        logic signed [15:0] out_quat_y;
        logic signed [15:0] out_quat_z;
        logic signed [15:0] out_quat_w;
    } out_item_t;

    // Sample word layout in storage: time, six motion words, four attitude words.
    localparam int unsigned SAMPLE_W = 32 + 6 * 32 + 4 * 16;

    // Commands to the shared divide and root unit.
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [63:0] num;
        logic [63:0] den;
    } du_cmd_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [63:0] rem;
    } du_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/itsi_ram.sv -----
// Generic single-port RAM with registered read data.
// Depends on nothing.
`default_nettype none
module itsi_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- rtl/itsi_divsqrt.sv -----
// Shared bit-serial unit: unsigned 64-bit restoring division or 64-bit integer
// square root, one bit per cycle. Depends on itsi_pkg.
`default_nettype none
module itsi_divsqrt (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire itsi_pkg::du_cmd_t cmd,
    output itsi_pkg::du_rsp_t     rsp
);
    import itsi_pkg::*;

    logic        busy_reg, busy_next;
    logic        sq_reg, sq_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] den_reg, den_next;
    logic [63:0] quo_reg, quo_next;
    logic [65:0] rem_reg, rem_next;
    logic        done_reg, done_next;
    logic [65:0] trial;
    logic [65:0] rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        sq_next   = sq_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        rem_sh    = '0;
        trial     = '0;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            sq_next   = cmd.is_sqrt;
            cnt_next  = cmd.is_sqrt ? 7'd32 : 7'd64;
            num_next  = cmd.num;
            den_next  = cmd.den;
            quo_next  = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (sq_reg)
            begin
                rem_sh = {rem_reg[63:0], num_reg[63:62]};
                trial  = {quo_reg[63:0], 2'b01};
                num_next = {num_reg[61:0], 2'b00};
            end
            else
            begin
                rem_sh = {rem_reg[64:0], num_reg[63]};
                trial  = {2'b00, den_reg};
                num_next = {num_reg[62:0], 1'b0};
            end
            if (rem_sh >= trial)
            begin
                rem_next = rem_sh - trial;
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg  <= sq_next;
        num_reg <= num_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg[63:0];

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divsqrt done while still busy");
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != 7'd0)
        else $error("divsqrt busy with zero count");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> busy_reg)
        else $error("divsqrt did not start");
endmodule
`default_nettype wire

// ----- rtl/imu_time_sync_interpolator_unit.sv -----
// Top level of the IMU time sync interpolator: sample FIFO, sequencer, and one
// shared multiplier plus divide/root unit. Depends on itsi_pkg, itsi_ram, itsi_divsqrt.
//
// A push item is written to the sample store in the cycle it is accepted, so pushes
// can follow each other with no gap. A sync item reads the two oldest samples and
// decides (states CHK, RDF, RDF2, DEC), going back to CHK for every stale sample it
// pops. It then interpolates ten channels one at a time. Each channel takes two
// multiplies, a bit-serial division in the shared unit, and a store. Squaring of the
// four attitude results, a square root and four divisions for the quaternion follow,
// and the OUT state hands the item to the output register. Equal neighbor times skip
// the channel divisions, and a zero quaternion skips the quaternion divisions. A
// failing sync item goes straight to the output with fewer than two samples stored,
// otherwise after the decision and any pops. Input stall is high while a sync item is
// in work; a finished result waits in its own output register, so new input items are
// taken while it waits. The sample store is one RAM of FIFO_DEPTH words with no
// clearing pass.
`default_nettype none
module imu_time_sync_interpolator_unit #(
    parameter int unsigned FIFO_DEPTH = itsi_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire itsi_pkg::in_item_t   in_item,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output itsi_pkg::out_item_t       out_item,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [31:0]          cfg_data
);
    import itsi_pkg::*;

    localparam int unsigned AW = $clog2(FIFO_DEPTH);
    localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHK   = 5'd2;
    localparam logic [4:0] S_RDF   = 5'd3;
    localparam logic [4:0] S_RDF2  = 5'd4;
    localparam logic [4:0] S_DEC   = 5'd7;
    localparam logic [4:0] S_LOADF = 5'd8;
    localparam logic [4:0] S_MULA  = 5'd10;
    localparam logic [4:0] S_MULB  = 5'd11;
    localparam logic [4:0] S_DIV   = 5'd12;
    localparam logic [4:0] S_DIVW  = 5'd13;
    localparam logic [4:0] S_SQ    = 5'd14;
    localparam logic [4:0] S_SQRT  = 5'd15;
    localparam logic [4:0] S_SQRTW = 5'd16;
    localparam logic [4:0] S_QDIV  = 5'd17;
    localparam logic [4:0] S_QDIVW = 5'd18;
    localparam logic [4:0] S_OUT   = 5'd19;

    logic [4:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [31:0]   gap_reg;
    logic [31:0]   t_reg, t_next;
    logic [31:0]   ft_reg, ft_next;
    logic [3:0]    ch_reg, ch_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [63:0]   qsq_reg, qsq_next;
    logic [63:0]   nrm_reg, nrm_next;
    logic [SAMPLE_W-1:0] fsmp_reg, fsmp_next;
    logic [SAMPLE_W-1:0] bsmp_reg, bsmp_next;
    logic [31:0]   res_reg [10];
    logic [31:0]   res_val;
    logic          res_we;
    logic          fail_reg, fail_next;
    logic          ov_reg, ov_next;
    out_item_t     out_item_reg, out_item_next;
    logic          out_load;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;
    du_cmd_t       du_cmd;
    du_rsp_t       du_rsp;

    logic [31:0]   d_w, wf_w, wb_w;
    logic signed [31:0] fv, bv;
    logic signed [63:0] prod;
    logic signed [31:0] mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   mag;
    logic          neg_reg, neg_next;
    logic [63:0]   qround;
    logic signed [15:0] qc;
    logic [AW-1:0] slot1;
    logic [AW-1:0] tail_slot;
    logic [SW-1:0] next_sum;
    logic [SW-1:0] tail_sum;

    assign cfg_ready = (state_reg == S_IDLE) && !ov_reg;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_item  = out_item_reg;

    assign next_sum  = SW'(head_reg) + SW'(1);
    assign tail_sum  = SW'(head_reg) + SW'(fill_reg);
    assign slot1     = (next_sum >= SW'(FIFO_DEPTH)) ? AW'(next_sum - SW'(FIFO_DEPTH))
                                                     : AW'(next_sum);
    assign tail_slot = (tail_sum >= SW'(FIFO_DEPTH)) ? AW'(tail_sum - SW'(FIFO_DEPTH))
                                                     : AW'(tail_sum);
    assign d_w   = bsmp_reg[SAMPLE_W-1 -: 32] - ft_reg;
    assign wf_w  = bsmp_reg[SAMPLE_W-1 -: 32] - t_reg;
    assign wb_w  = t_reg - ft_reg;

    itsi_ram #(.WIDTH(SAMPLE_W), .DEPTH(FIFO_DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    itsi_divsqrt u_du (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (du_cmd),
        .rsp   (du_rsp)
    );

    // Channel field extraction: channels 0..5 are motion, 6..9 attitude.
    always_comb
    begin
        if (ch_reg < 4'd6)
        begin
            fv = fsmp_reg[SAMPLE_W-33-32*ch_reg -: 32];
            bv = bsmp_reg[SAMPLE_W-33-32*ch_reg -: 32];
        end
        else
        begin
            fv = 32'(signed'(fsmp_reg[63-16*(ch_reg-4'd6) -: 16]));
            bv = 32'(signed'(bsmp_reg[63-16*(ch_reg-4'd6) -: 16]));
        end
    end

    assign prod = mul_a * $signed({1'b0, mul_b});
    assign mag  = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
    assign qround = du_rsp.quo;
    always_comb
    begin
        if (qround > 64'd32767)
        begin
            qc = neg_reg ? 16'sh8000 : 16'sd32767;
        end
        else
        begin
            qc = neg_reg ? 16'(-$signed(qround[16:0])) : 16'(qround[15:0]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        t_next     = t_reg;
        ft_next    = ft_reg;
        ch_next    = ch_reg;
        acc_next   = acc_reg;
        qsq_next   = qsq_reg;
        nrm_next   = nrm_reg;
        fsmp_next  = fsmp_reg;
        bsmp_next  = bsmp_reg;
        fail_next  = fail_reg;
        ov_next    = ov_reg;
        neg_next   = neg_reg;
        out_load   = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = head_reg;
        ram_wdata  = {in_item.timestamp, in_item.accel_x, in_item.accel_y, in_item.accel_z,
                      in_item.gyro_x, in_item.gyro_y, in_item.gyro_z, in_item.quat_x,
                      in_item.quat_y, in_item.quat_z, in_item.quat_w};
        du_cmd     = '0;
        mul_a      = fv;
        mul_b      = wf_w;
        res_we     = 1'b0;
        res_val    = '0;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    t_next = in_item.timestamp;
                    if (in_item.command == CMD_PUSH)
                    begin
                        ram_we = 1'b1;
                        if (fill_reg >= CW'(FIFO_DEPTH))
                        begin
                            ram_addr  = head_reg;
                            head_next = slot1;
                        end
                        else
                        begin
                            ram_addr  = tail_slot;
                            fill_next = fill_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        fail_next  = 1'b1;
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                if (fill_reg < CW'(2))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    ram_addr   = head_reg;
                    state_next = S_RDF;
                end
            end
            S_RDF:
            begin
                fsmp_next  = ram_rdata;
                ft_next    = ram_rdata[SAMPLE_W-1 -: 32];
                ram_addr   = slot1;
                state_next = S_RDF2;
            end
            S_RDF2:
            begin
                bsmp_next  = ram_rdata;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (ft_reg > t_reg)
                begin
                    state_next = S_OUT;
                end
                else if (bsmp_reg[SAMPLE_W-1 -: 32] < t_reg)
                begin
                    head_next  = slot1;
                    fill_next  = fill_reg - CW'(1);
                    state_next = S_CHK;
                end
                else if ((t_reg - ft_reg > gap_reg) ||
                         (bsmp_reg[SAMPLE_W-1 -: 32] - t_reg > gap_reg))
                begin
                    head_next  = slot1;
                    fill_next  = fill_reg - CW'(1);
                    state_next = S_OUT;
                end
                else
                begin
                    fail_next  = 1'b0;
                    ch_next    = '0;
                    qsq_next   = '0;
                    state_next = S_MULA;
                end
            end
            S_MULA:
            begin
                if (d_w == 32'd0)
                begin
                    acc_next   = 64'(fv);
                    state_next = S_DIVW;
                end
                else
                begin
                    mul_a      = fv;
                    mul_b      = wf_w;
                    acc_next   = prod;
                    state_next = S_MULB;
                end
            end
            S_MULB:
            begin
                mul_a      = bv;
                mul_b      = wb_w;
                acc_next   = acc_reg + prod;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                neg_next     = acc_reg[63];
                du_cmd.start = 1'b1;
                du_cmd.num   = mag + 64'(d_w >> 1);
                du_cmd.den   = 64'(d_w);
                state_next   = S_LOADF;
            end
            S_LOADF:
            begin
                if (du_rsp.done)
                begin
                    acc_next   = neg_reg ? -$signed(du_rsp.quo) : $signed(du_rsp.quo);
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                res_we  = 1'b1;
                res_val = acc_reg[31:0];
                if (ch_reg == 4'd9)
                begin
                    state_next = S_SQ;
                    ch_next    = 4'd6;
                end
                else
                begin
                    ch_next    = ch_reg + 4'd1;
                    state_next = S_MULA;
                end
            end
            S_SQ:
            begin
                mul_b    = res_reg[ch_reg][31] ? 32'(-$signed(res_reg[ch_reg]))
                                               : res_reg[ch_reg];
                mul_a    = $signed(mul_b);
                qsq_next = qsq_reg + $unsigned(prod);
                if (ch_reg == 4'd9)
                begin
                    state_next = S_SQRT;
                end
                else
                begin
                    ch_next = ch_reg + 4'd1;
                end
            end
            S_SQRT:
            begin
                du_cmd.start   = 1'b1;
                du_cmd.is_sqrt = 1'b1;
                du_cmd.num     = {qsq_reg[35:0], 28'd0};
                state_next     = S_SQRTW;
            end
            S_SQRTW:
            begin
                if (du_rsp.done)
                begin
                    nrm_next   = du_rsp.quo;
                    ch_next    = 4'd6;
                    state_next = S_QDIV;
                end
            end
            S_QDIV:
            begin
                if (nrm_reg == 64'd0)
                begin
                    res_we  = 1'b1;
                    res_val = '0;
                    if (ch_reg == 4'd9)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        ch_next = ch_reg + 4'd1;
                    end
                end
                else
                begin
                    neg_next     = res_reg[ch_reg][31];
                    du_cmd.start = 1'b1;
                    du_cmd.num   = ((res_reg[ch_reg][31] ? 64'(-$signed(res_reg[ch_reg]))
                                     : 64'(res_reg[ch_reg])) << 28) + (nrm_reg >> 1);
                    du_cmd.den   = nrm_reg;
                    state_next   = S_QDIVW;
                end
            end
            S_QDIVW:
            begin
                if (du_rsp.done)
                begin
                    res_we  = 1'b1;
                    res_val = 32'(qc);
                    if (ch_reg == 4'd9)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 4'd1;
                        state_next = S_QDIV;
                    end
                end
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            gap_reg   <= MAX_GAP_RST;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            ov_reg    <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                gap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        ft_reg   <= ft_next;
        ch_reg   <= ch_next;
        acc_reg  <= acc_next;
        qsq_reg  <= qsq_next;
        nrm_reg  <= nrm_next;
        fsmp_reg <= fsmp_next;
        bsmp_reg <= bsmp_next;
        fail_reg <= fail_next;
        neg_reg  <= neg_next;
        if (res_we)
        begin
            res_reg[ch_reg] <= res_val;
        end
        if (out_load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_comb
    begin
        out_item_next             = '0;
        out_item_next.out_time    = t_reg;
        out_item_next.sync_status = fail_reg ? STATUS_FAIL : STATUS_OK;
        if (!fail_reg)
        begin
            out_item_next.out_accel_x = res_reg[0];
            out_item_next.out_accel_y = res_reg[1];
            out_item_next.out_accel_z = res_reg[2];
            out_item_next.out_gyro_x  = res_reg[3];
            out_item_next.out_gyro_y  = res_reg[4];
            out_item_next.out_gyro_z  = res_reg[5];
            out_item_next.out_quat_x  = res_reg[6][15:0];
            out_item_next.out_quat_y  = res_reg[7][15:0];
            out_item_next.out_quat_z  = res_reg[8][15:0];
            out_item_next.out_quat_w  = res_reg[9][15:0];
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(FIFO_DEPTH))
        else $error("fill count above depth");
    a_push_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_item.command == CMD_PUSH) |=> !$rose(ov_reg))
        else $error("push produced a result");
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("input open while busy");
endmodule
`default_nettype wire
